// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg : shared types and constants for the escape-time unit
// Fixed-point format, register indexes and reset values, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

  // Word format: signed Q4.28 by default
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 28;

  // Default field widths
  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;

  // Step registers hold one bit less than a word
  localparam int STEP_W = 31;

  // Escape when |z|^2 reaches 4.0, that is 2^(2*FRAC_BITS + 2) at full width
  localparam int              PROD_W     = 2 * WORD_W;
  localparam int              ESC_LOG2   = 2 * FRAC_BITS + 2;
  localparam bit              ESC_NEVER  = (ESC_LOG2 >= PROD_W);
  localparam logic [PROD_W-1:0] ESC_LIMIT =
    ESC_NEVER ? '0 : (PROD_W'(1) << ESC_LOG2);

  // Configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_MAX  = 3'd4;

  // Reset values: -2.0, -1.5, 3/1024, 256 iterations
  localparam logic [WORD_W-1:0] REAL_MIN_RST  = 32'hE000_0000;
  localparam logic [WORD_W-1:0] IMAG_MIN_RST  = 32'hE800_0000;
  localparam logic [STEP_W-1:0] REAL_STEP_RST = 31'd786432;
  localparam logic [STEP_W-1:0] IMAG_STEP_RST = 31'd786432;
  localparam logic [CFG_W-1:0]  ITER_MAX_RST  = 32'd256;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // take a pixel, form pixel*step
    logic load;    // form c, clear z and the count
    logic mul;     // form the two squares and the cross product
    logic step;    // write back z, bump the count
    logic finish;  // latch the count as the result
  } mbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;    // escaped or limit reached
  } mbe_sts_t;

endpackage

// ----- rtl/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl : sequencer for the escape-time unit
// Walks map, load, then multiply / update pairs until the datapath reports a
// stop, and strobes done for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mbe_pkg::mbe_sts_t sts,
  output mbe_pkg::mbe_cmd_t cmd,
  output logic            busy,
  output logic            done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_MAP;
      S_MAP:  state_next = S_LOAD;
      S_LOAD: state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = sts.stop ? S_IDLE : S_MUL;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept = (state == S_IDLE) && start;
    cmd.load   = (state == S_LOAD);
    cmd.mul    = (state == S_MUL);
    cmd.step   = (state == S_UPD) && !sts.stop;
    cmd.finish = (state == S_UPD) && sts.stop;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("work ended without a result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted pixel did not start work");
`endif

endmodule

// ----- rtl/mbe_dp.sv -----
// ----------------------------------------------------------------------------
// mbe_dp : datapath for the escape-time unit
// Holds the region registers, maps a pixel to c, and runs z = z*z + c with a
// registered product stage ahead of the update and escape test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_dp #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS,
  parameter int ITER_BITS  = mbe_pkg::ITER_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mbe_pkg::mbe_cmd_t               cmd,
  output mbe_pkg::mbe_sts_t               sts,
  input  logic [COORD_BITS-1:0]           pixel_x,
  input  logic [COORD_BITS-1:0]           pixel_y,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]       cfg_data,
  output logic [ITER_BITS-1:0]            iterations
);

  localparam int W  = mbe_pkg::WORD_W;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int MW = COORD_BITS + mbe_pkg::STEP_W;

  // Region registers
  logic signed [W-1:0]              real_min;
  logic signed [W-1:0]              imag_min;
  logic [mbe_pkg::STEP_W-1:0]       real_step;
  logic [mbe_pkg::STEP_W-1:0]       imag_step;
  logic [ITER_BITS-1:0]             iter_max;

  // Working registers
  logic [W-1:0]        map_r;
  logic [W-1:0]        map_i;
  logic signed [W-1:0] cr;
  logic signed [W-1:0] ci;
  logic signed [W-1:0] zr;
  logic signed [W-1:0] zi;
  logic signed [PW-1:0] rr;
  logic signed [PW-1:0] ii;
  logic signed [PW-1:0] ri;
  logic [ITER_BITS-1:0] count;

  logic [MW-1:0]        prod_r;
  logic [MW-1:0]        prod_i;
  logic signed [PW-1:0] sq;
  logic signed [PW-1:0] sq_sh;
  logic signed [PW-1:0] ri_sh;
  logic [PW-1:0]        mag_sq;
  logic                 in_radius;
  logic [W-1:0]         zr_next;
  logic [W-1:0]         zi_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      real_min  <= mbe_pkg::REAL_MIN_RST;
      imag_min  <= mbe_pkg::IMAG_MIN_RST;
      real_step <= mbe_pkg::REAL_STEP_RST;
      imag_step <= mbe_pkg::IMAG_STEP_RST;
      iter_max  <= ITER_BITS'(mbe_pkg::ITER_MAX_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_REAL_MIN:  real_min  <= cfg_data[W-1:0];
        mbe_pkg::REG_IMAG_MIN:  imag_min  <= cfg_data[W-1:0];
        mbe_pkg::REG_REAL_STEP: real_step <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_IMAG_STEP: imag_step <= cfg_data[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ITER_MAX:  iter_max  <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pixel times step, wrapped to a word
  assign prod_r = pixel_x * real_step;
  assign prod_i = pixel_y * imag_step;

  // Escape test on the current z: squares are non-negative, sum fits
  assign mag_sq    = $unsigned(rr) + $unsigned(ii);
  assign in_radius = mbe_pkg::ESC_NEVER || (mag_sq < mbe_pkg::ESC_LIMIT);

  // Next z: floor-shifted products plus c, wrapped to a word
  assign sq      = rr - ii;
  assign sq_sh   = sq >>> mbe_pkg::FRAC_BITS;
  assign ri_sh   = ri >>> (mbe_pkg::FRAC_BITS - 1);
  assign zr_next = sq_sh[W-1:0] + cr;
  assign zi_next = ri_sh[W-1:0] + ci;

  assign sts.stop = !((count < iter_max) && in_radius);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      map_r <= prod_r[W-1:0];
      map_i <= prod_i[W-1:0];
    end
    if (cmd.load) begin
      cr    <= real_min + map_r;
      ci    <= imag_min + map_i;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end
    if (cmd.mul) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.step) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= count + ITER_BITS'(1);
    end
    if (cmd.finish) begin
      iterations <= count;
    end
  end

`ifndef ASSERT_OFF
  a_step_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (count < iter_max))
    else $error("iteration taken at or past the limit");

  a_step_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> cmd.mul)
    else $error("update not followed by a product pass");
`endif

endmodule

// ----- rtl/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time : Mandelbrot escape-count unit
// Sequence: for each accepted pixel the unit maps it, loads c, runs one multiply
//   step and one update step per iteration, then the final multiply and test,
//   and then raises done.
// One pixel at a time: busy holds off start until the result; start is taken in the done cycle.
// Reset: rst, synchronous, idles the sequencer and restores the default view.
// The result is not held off: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS,
  parameter int ITER_BITS  = mbe_pkg::ITER_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Pixel in: a beat moves when start is high and busy is low
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         pixel_x,
  input  logic [COORD_BITS-1:0]         pixel_y,
  // Result out: one beat per pixel, valid only while done is high
  output logic                          done,
  output logic [ITER_BITS-1:0]          iterations,
  // Register writes: real_min, imag_min, real_step, imag_step, iter_max
  input  logic                          cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]     cfg_data
);

  // Commands down, stop status up; nothing else crosses the boundary
  mbe_pkg::mbe_cmd_t cmd;
  mbe_pkg::mbe_sts_t sts;

  // Sequencer: idle, map the pixel, load c, then alternate the product
  // cycle and the update cycle until the point escapes or the limit is hit
  mbe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: region registers, pixel mapping, z*z + c in Q4.28 with wrap,
  // escape test against 4.0 at full product width, iteration count
  mbe_dp #(
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .iterations (iterations)
  );

endmodule
